>>> src/tdp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdp_pkg
// Shared types and constants of the two-dimensional parity frame checker.
// ----------------------------------------------------------------------------
package tdp_pkg;

   localparam int DEFAULT_MAX_ROWS = 64;
   localparam int COLUMN_DIGITS    = 8;

   localparam logic [7:0] SEPARATOR  = 8'h7C;
   localparam logic [7:0] DIGIT_ZERO = 8'h30;
   localparam logic [7:0] DIGIT_ONE  = 8'h31;

   localparam logic [6:0] TALLY_MAX = 7'd127;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_PARITY = 2'd1,
      STATUS_FORMAT = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      PHASE_HEADER  = 2'd0,
      PHASE_DIGITS  = 2'd1,
      PHASE_MESSAGE = 2'd2
   } phase_type;

   typedef struct packed {
      status_type status;
      logic [7:0] column_mismatch_mask;
      logic [6:0] row_mismatch_count;
   } result_type;

endpackage

>>> src/tdp_channels_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdp channel interfaces
// Valid/ready channels for frame bytes and for check results.
// ----------------------------------------------------------------------------
interface tdp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last;

   modport source (output valid, output data_byte, output last, input ready);
   modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface tdp_rsp_if;
   logic               valid;
   logic               ready;
   tdp_pkg::status_type status;
   logic [7:0]         column_mismatch_mask;
   logic [6:0]         row_mismatch_count;

   modport source (output valid, output status, output column_mismatch_mask,
                   output row_mismatch_count, input ready);
   modport sink   (input valid, input status, input column_mismatch_mask,
                   input row_mismatch_count, output ready);
endinterface

>>> src/tdp_row_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdp_row_store
// One-bit-wide memory of received row parity digits, registered read.
// ----------------------------------------------------------------------------
module tdp_row_store #(
   parameter int ADDR_WIDTH = 6
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_WIDTH-1:0] wr_addr,
   input  logic                  wr_bit,
   input  logic [ADDR_WIDTH-1:0] rd_addr,
   output logic                  rd_bit
);

   localparam int Depth = 1 << ADDR_WIDTH;

   logic mem [Depth];
   logic rd_bit_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_bit;
      end
      rd_bit_ff <= mem[rd_addr];
   end

   assign rd_bit = rd_bit_ff;

endmodule

>>> src/tdp_frame_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdp_frame_tracker
// Frame phase, digit capture, running parities and the end-of-frame verdict.
// ----------------------------------------------------------------------------
module tdp_frame_tracker #(
   parameter int MAX_ROWS   = 64,
   parameter int ADDR_WIDTH = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  take,
   input  logic [7:0]            data_byte,
   input  logic                  last,
   output logic                  wr_en,
   output logic [ADDR_WIDTH-1:0] wr_addr,
   output logic                  wr_bit,
   output logic [ADDR_WIDTH-1:0] rd_addr,
   input  logic                  rd_bit,
   output logic                  res_valid,
   output tdp_pkg::result_type   res
);
   import tdp_pkg::*;

   localparam int DW = $clog2(MAX_ROWS + COLUMN_DIGITS + 2);
   localparam int MW = $clog2(MAX_ROWS + 1);

   localparam logic [DW-1:0] PosLimit  = DW'(MAX_ROWS + COLUMN_DIGITS + 1);
   localparam logic [DW-1:0] RowEnd    = DW'(MAX_ROWS + COLUMN_DIGITS);
   localparam logic [DW-1:0] ColDigits = DW'(COLUMN_DIGITS);
   localparam logic [MW-1:0] MsgLimit  = MW'(MAX_ROWS);

   phase_type      phase_ff, phase_in, phase_upd;
   logic [DW-1:0]  pos_ff, pos_in, pos_upd;
   logic [7:0]     col_dig_ff, col_dig_in, col_dig_upd;
   logic [7:0]     acc_ff, acc_in, acc_upd;
   logic [MW-1:0]  msg_ff, msg_in, msg_upd;
   logic [6:0]     tally_ff, tally_in, tally_upd;
   logic           fault_ff, fault_in, fault_upd;

   logic           is_sep, is_digit;
   logic [DW-1:0]  row_pos;
   logic [DW-1:0]  msg_ext;
   logic [7:0]     mask;
   logic           bad_format;

   assign is_sep   = (data_byte == SEPARATOR);
   assign is_digit = (data_byte == DIGIT_ZERO) || (data_byte == DIGIT_ONE);
   assign row_pos  = pos_ff - ColDigits;

   // Next phase.
   always_comb begin
      phase_upd = phase_ff;
      case (phase_ff)
         PHASE_HEADER:  if (is_sep) phase_upd = PHASE_DIGITS;
         PHASE_DIGITS:  if (is_sep) phase_upd = PHASE_MESSAGE;
         PHASE_MESSAGE: phase_upd = PHASE_MESSAGE;
         default:       phase_upd = PHASE_HEADER;
      endcase
      if (!take) begin
         phase_in = phase_ff;
      end else if (last) begin
         phase_in = PHASE_HEADER;
      end else begin
         phase_in = phase_upd;
      end
   end

   // Datapath updates for the byte in hand.
   always_comb begin
      pos_upd     = pos_ff;
      col_dig_upd = col_dig_ff;
      acc_upd     = acc_ff;
      msg_upd     = msg_ff;
      tally_upd   = tally_ff;
      fault_upd   = fault_ff;
      wr_en       = 1'b0;
      case (phase_ff)
         PHASE_DIGITS: begin
            if (!is_sep) begin
               if (!is_digit) begin
                  fault_upd = 1'b1;
               end else begin
                  if (pos_ff < ColDigits) begin
                     col_dig_upd[~pos_ff[2:0]] = data_byte[0];
                  end else if (pos_ff < RowEnd) begin
                     wr_en = take;
                  end else begin
                     fault_upd = 1'b1;
                  end
                  if (pos_ff < PosLimit) begin
                     pos_upd = pos_ff + 1'b1;
                  end
               end
            end
         end
         PHASE_MESSAGE: begin
            if (msg_ff >= MsgLimit) begin
               fault_upd = 1'b1;
            end else begin
               acc_upd = acc_ff ^ data_byte;
               // Only rows whose digit arrived in this frame are checked.
               if (msg_ext + ColDigits < pos_ff) begin
                  if ((rd_bit != ~^data_byte) && (tally_ff < TALLY_MAX)) begin
                     tally_upd = tally_ff + 1'b1;
                  end
               end
               msg_upd = msg_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   assign msg_ext = DW'(msg_ff);
   assign wr_addr = row_pos[ADDR_WIDTH-1:0];
   assign wr_bit  = data_byte[0];

   always_comb begin
      if (!take) begin
         pos_in = pos_ff;  col_dig_in = col_dig_ff; acc_in = acc_ff;
         msg_in = msg_ff;  tally_in = tally_ff;     fault_in = fault_ff;
      end else if (last) begin
         pos_in = '0;      col_dig_in = '0;         acc_in = 8'hFF;
         msg_in = '0;      tally_in = '0;           fault_in = 1'b0;
      end else begin
         pos_in = pos_upd; col_dig_in = col_dig_upd; acc_in = acc_upd;
         msg_in = msg_upd; tally_in = tally_upd;     fault_in = fault_upd;
      end
   end

   // The row digit for the next message byte is fetched ahead, through the registered read.
   assign rd_addr = msg_in[ADDR_WIDTH-1:0];

   // Verdict on the state as it stands after the final byte.
   assign mask       = col_dig_upd ^ acc_upd;
   assign bad_format = fault_upd || (phase_upd != PHASE_MESSAGE) ||
                       (pos_upd < ColDigits) ||
                       ((pos_upd - ColDigits) != DW'(msg_upd));

   always_comb begin
      res_valid = take && last;
      if (bad_format) begin
         res.status               = STATUS_FORMAT;
         res.column_mismatch_mask = '0;
         res.row_mismatch_count   = '0;
      end else begin
         res.status               = ((mask != 8'h00) || (tally_upd != 7'd0)) ?
                                    STATUS_PARITY : STATUS_OK;
         res.column_mismatch_mask = mask;
         res.row_mismatch_count   = tally_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PHASE_HEADER;
         pos_ff     <= '0;
         col_dig_ff <= '0;
         acc_ff     <= 8'hFF;
         msg_ff     <= '0;
         tally_ff   <= '0;
         fault_ff   <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         pos_ff     <= pos_in;
         col_dig_ff <= col_dig_in;
         acc_ff     <= acc_in;
         msg_ff     <= msg_in;
         tally_ff   <= tally_in;
         fault_ff   <= fault_in;
      end
   end

`ifndef ASSERT_OFF
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      take && last |=> phase_ff == PHASE_HEADER && msg_ff == '0 && pos_ff == '0)
      else $error("frame state not cleared after final byte");

   a_header_idle: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PHASE_HEADER |-> pos_ff == '0 && msg_ff == '0 && tally_ff == '0)
      else $error("counters moved during header phase");

   a_msg_bound: assert property (@(posedge clock) disable iff (reset)
      msg_ff <= MsgLimit && pos_ff <= PosLimit)
      else $error("frame counter beyond its bound");

   a_no_write_in_message: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> phase_ff == PHASE_DIGITS && pos_ff >= ColDigits)
      else $error("row store written outside row digits");
`endif

endmodule

>>> src/two_dimensional_parity_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_dimensional_parity_frame_checker
// Odd two-dimensional parity check over a framed byte stream.
//
//   channel  dir  fields                                          per transfer
//   req_ch   in   data_byte[7:0], last                            one byte
//   rsp_ch   out  status[1:0], column_mismatch_mask[7:0],
//                 row_mismatch_count[6:0]                         one frame
//
// One byte is taken per cycle while req_ch.ready is high; the verdict of a frame
// appears in the cycle after its final byte is taken, from the result register.
// The row digit read for the next message byte comes from a registered
// memory read issued ahead of that byte, so no bubble is needed.
// A waiting result stalls input only when the sink holds ready low.
// Reset is synchronous and returns the checker to the header phase; the row
// digit memory needs no clearing.
// ----------------------------------------------------------------------------
module two_dimensional_parity_frame_checker #(
   parameter int MAX_ROWS = tdp_pkg::DEFAULT_MAX_ROWS
) (
   input  logic      clock,
   input  logic      reset,
   tdp_req_if.sink   req_ch,
   tdp_rsp_if.source rsp_ch
);
   import tdp_pkg::*;

   localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

   logic            take;
   logic            wr_en, wr_bit, rd_bit;
   logic [AW-1:0]   wr_addr, rd_addr;
   logic            res_valid;
   result_type      res;

   logic            rsp_valid_ff, rsp_valid_in;
   result_type      rsp_data_ff;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign take         = req_ch.valid && req_ch.ready;

   tdp_row_store #(
      .ADDR_WIDTH (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_bit  (wr_bit),
      .rd_addr (rd_addr),
      .rd_bit  (rd_bit)
   );

   tdp_frame_tracker #(
      .MAX_ROWS   (MAX_ROWS),
      .ADDR_WIDTH (AW)
   ) u_tracker (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .data_byte (req_ch.data_byte),
      .last      (req_ch.last),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_bit    (wr_bit),
      .rd_addr   (rd_addr),
      .rd_bit    (rd_bit),
      .res_valid (res_valid),
      .res       (res)
   );

   assign rsp_valid_in = res_valid || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_ch.valid                = rsp_valid_ff;
   assign rsp_ch.status               = rsp_data_ff.status;
   assign rsp_ch.column_mismatch_mask = rsp_data_ff.column_mismatch_mask;
   assign rsp_ch.row_mismatch_count   = rsp_data_ff.row_mismatch_count;

`ifndef ASSERT_OFF
   a_format_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.status == STATUS_FORMAT |->
         rsp_data_ff.column_mismatch_mask == 8'h00 &&
         rsp_data_ff.row_mismatch_count == 7'd0)
      else $error("format error result carries mismatch data");

   a_ok_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.status == STATUS_OK |->
         rsp_data_ff.column_mismatch_mask == 8'h00 &&
         rsp_data_ff.row_mismatch_count == 7'd0)
      else $error("ok result carries mismatches");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ch.ready && !(take && req_ch.last) |=> !rsp_valid_ff)
      else $error("result appeared without a final byte");
`endif

endmodule
